FILE: design/bpe_pkg.sv
// Shared constants, payload types and control structs for the branch path enumerator.
`timescale 1ns / 1ps
`default_nettype none

package bpe_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned FracBits   = 16;

  localparam int unsigned ValW   = FracBits + 1;
  localparam int unsigned ProdW  = 2 * ValW;
  localparam int unsigned AddrW  = $clog2(StackDepth);
  localparam int unsigned CountW = $clog2(StackDepth + 1);
  localparam int unsigned PosW   = $clog2(2 * StackDepth);

  localparam logic [ValW-1:0]   OneFix    = {1'b1, {FracBits{1'b0}}};
  localparam logic [PosW-1:0]   PosMax    = PosW'(2 * StackDepth - 1);
  localparam logic [CountW-1:0] DepthFull = CountW'(StackDepth);

  localparam logic [1:0] KindCheck = 2'd0;
  localparam logic [1:0] KindRound = 2'd1;
  localparam logic [1:0] KindClear = 2'd2;

  typedef struct packed {
    logic [1:0]      kind;
    logic            branch_taken;
    logic [ValW-1:0] tendency;
  } in_item_t;

  typedef struct packed {
    logic            truth_out;
    logic            more_rounds;
    logic [ValW-1:0] weight;
    logic            overflow;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic replay_mul;
    logic pop_read;
    logic pop_check;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_replay;
    logic is_round;
    logic stack_empty;
    logic top_falsified;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/bpe_ctrl.sv
// Sequencing state machine of the branch path enumerator.
`timescale 1ns / 1ps
`default_nettype none

module bpe_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire bpe_pkg::dp_stat_t stat_i,
  output bpe_pkg::dp_cmd_t      cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StExec   = 3'd1;
  localparam logic [2:0] StRmul   = 3'd2;
  localparam logic [2:0] StPopRd  = 3'd3;
  localparam logic [2:0] StPopChk = 3'd4;
  localparam logic [2:0] StFin    = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        if (stat_i.is_replay) begin
          state_d = StRmul;
        end else if (stat_i.is_round) begin
          state_d = StPopRd;
        end else begin
          state_d = StFin;
        end
      end
      StRmul: begin
        cmd_o.replay_mul = 1'b1;
        state_d          = StFin;
      end
      StPopRd: begin
        if (stat_i.stack_empty) begin
          state_d = StFin;
        end else begin
          cmd_o.pop_read = 1'b1;
          state_d        = StPopChk;
        end
      end
      StPopChk: begin
        cmd_o.pop_check = 1'b1;
        state_d = stat_i.top_falsified ? StPopRd : StFin;
      end
      StFin: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/bpe_datapath.sv
// Flag stack memory, path state registers, weight multiplier and output register.
`timescale 1ns / 1ps
`default_nettype none

module bpe_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bpe_pkg::in_item_t in_item_i,
  input  wire bpe_pkg::dp_cmd_t  cmd_i,
  output bpe_pkg::dp_stat_t      stat_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output bpe_pkg::out_item_t     out_item_o
);

  // Flag memory: 1 means falsified.
  logic flag_mem [bpe_pkg::StackDepth];
  logic rd_q;

  bpe_pkg::in_item_t item_q;
  logic [bpe_pkg::CountW-1:0] count_q;
  logic [bpe_pkg::PosW-1:0]   pos_q;
  logic                       has_last_q;
  logic [bpe_pkg::AddrW-1:0]  last_pos_q;
  logic [bpe_pkg::ValW-1:0]   weight_q;
  logic [bpe_pkg::ProdW-1:0]  prod_q;
  logic                       mul_pend_q;
  logic                       truth_q, more_q, ovf_q;
  logic                       out_valid_q;
  bpe_pkg::out_item_t         out_q;

  logic                       is_check, tend_pass, record_phase, is_record;
  logic                       fals;
  logic [bpe_pkg::ValW-1:0]   factor;
  logic [bpe_pkg::AddrW-1:0]  top_addr;
  logic [bpe_pkg::AddrW-1:0]  rd_addr;
  logic                       rd_en;
  logic [bpe_pkg::AddrW-1:0]  wr_addr;
  logic                       wr_en, wr_data;
  logic [bpe_pkg::PosW-1:0]   pos_next;
  logic [bpe_pkg::ValW-1:0]   new_weight;

  assign is_check     = (item_q.kind == bpe_pkg::KindCheck);
  // A tendency of zero, or of one and above, passes the outcome straight through.
  assign tend_pass    = (item_q.tendency == '0) || item_q.tendency[bpe_pkg::ValW-1];
  assign record_phase = !has_last_q || (pos_q > bpe_pkg::PosW'(last_pos_q));
  assign is_record    = is_check && !tend_pass && record_phase;
  assign fals         = rd_q && (pos_q < bpe_pkg::PosW'(count_q));
  assign top_addr     = bpe_pkg::AddrW'(count_q - bpe_pkg::CountW'(1));
  assign pos_next     = (pos_q == bpe_pkg::PosMax) ? pos_q : pos_q + bpe_pkg::PosW'(1);
  assign new_weight   = mul_pend_q ? prod_q[bpe_pkg::FracBits +: bpe_pkg::ValW] : weight_q;

  always_comb begin
    if (cmd_i.replay_mul && fals) begin
      factor = bpe_pkg::OneFix - item_q.tendency;
    end else begin
      factor = item_q.tendency;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = top_addr;
    if (cmd_i.exec && stat_o.is_replay) begin
      rd_en   = 1'b1;
      rd_addr = pos_q[bpe_pkg::AddrW-1:0];
    end else if (cmd_i.pop_read) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = top_addr;
    wr_data = 1'b1;
    if (cmd_i.exec && is_record && (count_q < bpe_pkg::DepthFull)) begin
      wr_en   = 1'b1;
      wr_addr = count_q[bpe_pkg::AddrW-1:0];
      wr_data = 1'b0;
    end else if (cmd_i.pop_check && !rd_q) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      flag_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= flag_mem[rd_addr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    if ((cmd_i.exec && is_record) || cmd_i.replay_mul) begin
      prod_q <= bpe_pkg::ProdW'(weight_q) * bpe_pkg::ProdW'(factor);
    end
    if (cmd_i.finish) begin
      out_q.truth_out   <= truth_q;
      out_q.more_rounds <= more_q;
      out_q.weight      <= new_weight;
      out_q.overflow    <= ovf_q;
    end
  end

  // Path state and per-item result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pos_q       <= '0;
      has_last_q  <= 1'b0;
      last_pos_q  <= '0;
      weight_q    <= bpe_pkg::OneFix;
      mul_pend_q  <= 1'b0;
      truth_q     <= 1'b0;
      more_q      <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        mul_pend_q <= 1'b0;
        truth_q    <= 1'b0;
        more_q     <= 1'b0;
        ovf_q      <= 1'b0;
      end
      if (cmd_i.exec) begin
        if (is_check && (tend_pass || record_phase)) begin
          truth_q <= item_q.branch_taken;
        end
        if (is_record) begin
          if (count_q < bpe_pkg::DepthFull) begin
            count_q <= count_q + bpe_pkg::CountW'(1);
          end else begin
            ovf_q <= 1'b1;
          end
          mul_pend_q <= 1'b1;
          pos_q      <= pos_next;
        end
        if (item_q.kind == bpe_pkg::KindClear) begin
          count_q    <= '0;
          pos_q      <= '0;
          has_last_q <= 1'b0;
          last_pos_q <= '0;
          weight_q   <= bpe_pkg::OneFix;
        end
      end
      if (cmd_i.replay_mul) begin
        truth_q    <= item_q.branch_taken ^ fals;
        mul_pend_q <= 1'b1;
        pos_q      <= pos_next;
      end
      if (cmd_i.pop_check) begin
        if (rd_q) begin
          count_q <= count_q - bpe_pkg::CountW'(1);
        end else begin
          has_last_q <= 1'b1;
          last_pos_q <= top_addr;
          weight_q   <= bpe_pkg::OneFix;
          pos_q      <= '0;
          more_q     <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        weight_q    <= new_weight;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.is_replay     = is_check && !tend_pass && !record_phase;
  assign stat_o.is_round      = (item_q.kind == bpe_pkg::KindRound);
  assign stat_o.stack_empty   = (count_q == '0);
  assign stat_o.top_falsified = rd_q;
  assign stat_o.out_free      = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

FILE: design/branch_path_enumerator_core.sv
// Top level of the branch path enumerator: controller plus datapath.
// The block walks, depth first, every path through a program's soft branches.
// Input channel (in_valid_i / in_stall_o / in_item_i): one transfer per item,
// taken when valid is high and stall is low. An item is a branch check, a
// next-round request or a new-tape clear. Output channel (out_valid_o /
// out_stall_i / out_item_o): one result transfer per input item, in order.
// Replay-phase checks register the flag memory read before the multiply;
// a next-round request pops falsified flags off the stack, each pop being
// one registered read of the flag memory and one compare. One item is in
// flight at a time: no new item is taken until the last one has finished.
// A finished result
// sits in the output register; while the receiver stalls, the next item is
// still taken, but its result waits in the final state until the register
// frees. Reset empties the stack, zeroes the position, forgets the last
// falsified marker and sets the path weight to 1.0; the flag memory itself is
// not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module branch_path_enumerator_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire bpe_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output bpe_pkg::out_item_t     out_item_o
);

  bpe_pkg::dp_cmd_t  cmd;
  bpe_pkg::dp_stat_t stat;
  logic              in_ready;

  // The controller sequences each item; the datapath holds the flag stack and all path state.
  bpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bpe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // New items are taken only while the controller is idle.
  assign in_stall_o = !in_ready;

endmodule

`default_nettype wire
